[sv/u8san_pkg.sv]
// shared types and constants for the utf8 stream sanitizer
// no dependencies; used by every module of the block
package u8san_pkg;

    localparam logic [7:0] REPL_RESET  = 8'h3F;
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;

    // one run of output bytes caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            str_end;
        logic            had_err;
    } t_run;

    // expected sequence length of a lead byte, 0 when not a lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

[sv/u8san_front.sv]
// front end: classifies each byte, holds partial sequences, builds output runs
// depends on u8san_pkg
module u8san_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    input  logic              i_full,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_push,
    output u8san_pkg::t_run   o_run
);

    logic [7:0]      r_repl;
    logic [2:0][7:0] r_pend;
    logic [2:0][7:0] n_pend;
    logic [1:0]      r_pcnt;
    logic [1:0]      n_pcnt;
    logic [2:0]      r_slen;
    logic [2:0]      n_slen;
    logic            r_err;
    logic            n_err;

    logic            take;
    logic            has_pend;
    logic            is_cont;
    logic [2:0]      len;
    logic            held_ok;
    logic [1:0]      flush_cnt;
    logic            tail_emit;
    logic [7:0]      tail_byte;
    logic            err_new;
    logic            err_final;

    assign take = i_valid && !i_full;

    always_comb begin
        has_pend  = (r_pcnt != 2'd0) && (r_slen != 3'd0);
        is_cont   = (i_byte & u8san_pkg::CONT_MASK) == u8san_pkg::CONT_TAG;
        len       = u8san_pkg::lead_len(i_byte);
        n_pend    = r_pend;
        n_pcnt    = r_pcnt;
        n_slen    = r_slen;
        held_ok   = 1'b0;
        flush_cnt = 2'd0;
        tail_emit = 1'b1;
        tail_byte = i_byte;
        err_new   = 1'b0;

        if (has_pend && is_cont) begin
            if ({1'b0, r_pcnt} + 3'd1 >= r_slen) begin
                // sequence complete, pass it through
                held_ok   = 1'b1;
                flush_cnt = r_pcnt;
                n_pcnt    = 2'd0;
                n_slen    = 3'd0;
            end else if (i_last) begin
                // cut off by the string end
                flush_cnt = r_pcnt;
                tail_byte = r_repl;
                err_new   = 1'b1;
                n_pcnt    = 2'd0;
                n_slen    = 3'd0;
            end else begin
                n_pend[r_pcnt] = i_byte;
                n_pcnt         = r_pcnt + 2'd1;
                tail_emit      = 1'b0;
            end
        end else begin
            if (has_pend) begin
                // broken sequence, replace what is held
                flush_cnt = r_pcnt;
                err_new   = 1'b1;
            end
            n_pcnt = 2'd0;
            n_slen = 3'd0;
            if (i_byte <= u8san_pkg::ASCII_MAX) begin
                tail_byte = i_byte;
            end else if (len == 3'd0 || i_last) begin
                tail_byte = r_repl;
                err_new   = 1'b1;
            end else begin
                n_pend[0] = i_byte;
                n_pcnt    = 2'd1;
                n_slen    = len;
                tail_emit = 1'b0;
            end
        end

        err_final = r_err || err_new;
        n_err     = err_final;
        if (i_last) begin
            n_pcnt = 2'd0;
            n_slen = 3'd0;
            n_err  = 1'b0;
        end

        for (int k = 0; k < 3; k++) begin
            if (2'(k) < flush_cnt) begin
                o_run.bytes[k] = held_ok ? r_pend[k] : r_repl;
            end else begin
                o_run.bytes[k] = tail_byte;
            end
        end
        o_run.bytes[3] = tail_byte;
        o_run.last_idx = tail_emit ? flush_cnt : flush_cnt - 2'd1;
        o_run.str_end  = i_last;
        o_run.had_err  = i_last && err_final;
        o_push         = take && (tail_emit || flush_cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= u8san_pkg::REPL_RESET;
            r_pcnt <= 2'd0;
            r_slen <= 3'd0;
            r_err  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_repl <= i_cfg_data;
            end
            if (take) begin
                r_pcnt <= n_pcnt;
                r_slen <= n_slen;
                r_err  <= n_err;
            end
        end
    end

    // held bytes are only read below the fill count
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pend <= n_pend;
        end
    end

endmodule

[sv/u8san_queue.sv]
// small fifo of output runs between the front and back ends
// depends on u8san_pkg
module u8san_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8san_pkg::t_run   i_run,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_avail,
    output u8san_pkg::t_run   o_run
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8san_pkg::t_run r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_run   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_run;
        end
    end

endmodule

[sv/u8san_back.sv]
// back end: serializes each queued run into one output byte per transaction
// depends on u8san_pkg
module u8san_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  u8san_pkg::t_run   i_run,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_run_last,
    output logic              o_out_string_end,
    output logic              o_out_string_had_error
);

    u8san_pkg::t_run r_run;
    logic            r_busy;
    logic [1:0]      r_idx;
    logic            at_last;
    logic            sent;
    logic            done_now;

    assign at_last  = r_idx == r_run.last_idx;
    assign sent     = r_busy && !i_out_stall;
    assign done_now = sent && at_last;
    assign o_pop    = i_avail && (!r_busy || done_now);

    assign o_out_valid            = r_busy;
    assign o_out_byte             = r_run.bytes[r_idx];
    assign o_out_run_last         = at_last;
    assign o_out_string_end       = at_last && r_run.str_end;
    assign o_out_string_had_error = at_last && r_run.had_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done_now) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (sent) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_run;
        end
    end

endmodule

[sv/utf8_stream_sanitizer.sv]
// utf8 stream sanitizer top level: front end, run queue, back end
// accepts one byte per cycle while the run queue has room; emits one byte per cycle while the output is not stalled
// an accepted byte's run is written to the run queue, then loaded into the back end run register before it is output
// a run of up to 4 bytes is sent one byte per output transaction; the back end serializer sets the rate
// synchronous active-low reset clears held sequence, queue and sets replacement byte to '?'
module utf8_stream_sanitizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_string_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_run_last,
    output logic       o_out_string_end,
    output logic       o_out_string_had_error
);

    u8san_pkg::t_run push_run;
    u8san_pkg::t_run head_run;
    logic            push;
    logic            pop;
    logic            full;
    logic            avail;

    assign o_in_stall = full;

    u8san_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .i_full     (full),
        .i_byte     (i_in_byte),
        .i_last     (i_in_string_last),
        .o_push     (push),
        .o_run      (push_run)
    );

    u8san_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (push_run),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_run   (head_run)
    );

    u8san_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_avail                (avail),
        .i_run                  (head_run),
        .o_pop                  (pop),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_out_byte             (o_out_byte),
        .o_out_run_last         (o_out_run_last),
        .o_out_string_end       (o_out_string_end),
        .o_out_string_had_error (o_out_string_had_error)
    );

endmodule

[dv/utf8_san_checker.sv]
// checker for the utf8 stream sanitizer: watches the config port and both channels,
// predicts the cleaned byte stream and compares every output transaction
// depends on u8san_pkg for the byte class constants and the replacement reset value
module utf8_san_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_string_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_run_last,
    input  logic       i_out_string_end,
    input  logic       i_out_string_had_error,
    output int         o_fail_count,
    output int         o_outstanding,
    output int         o_out_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
        logic       had_err;
    } t_clean_byte;

    logic [7:0]  repl_byte;
    logic [7:0]  held [3];
    logic [1:0]  held_cnt;
    logic [2:0]  seq_len;
    logic        err_seen;
    logic [7:0]  run_bytes [$];
    t_clean_byte expected_q [$];

    task automatic emit(input logic [7:0] b);
        run_bytes.push_back(b);
    endtask

    // every held byte becomes a replacement byte
    task automatic flush_held();
        for (int i = 0; i < held_cnt; i++) begin
            emit(repl_byte);
        end
        if (held_cnt != 0) begin
            err_seen = 1'b1;
        end
        held_cnt = 2'd0;
        seq_len  = 3'd0;
    endtask

    // byte arriving with nothing held
    task automatic take_lead(input logic [7:0] b, input logic last);
        logic [2:0] len;
        len = 3'd0;
        if ((b & u8san_pkg::LEAD2_MASK) == u8san_pkg::LEAD2_TAG) begin
            len = 3'd2;
        end else if ((b & u8san_pkg::LEAD3_MASK) == u8san_pkg::LEAD3_TAG) begin
            len = 3'd3;
        end else if ((b & u8san_pkg::LEAD4_MASK) == u8san_pkg::LEAD4_TAG) begin
            len = 3'd4;
        end
        if (b <= u8san_pkg::ASCII_MAX) begin
            emit(b);
        end else if (len == 3'd0 || last) begin
            err_seen = 1'b1;
            emit(repl_byte);
        end else begin
            held[0]  = b;
            held_cnt = 2'd1;
            seq_len  = len;
        end
    endtask

    task automatic sanitize_byte(input logic [7:0] b, input logic last);
        t_clean_byte cb;
        run_bytes.delete();
        if (seq_len != 3'd0 && held_cnt != 2'd0) begin
            if ((b & u8san_pkg::CONT_MASK) == u8san_pkg::CONT_TAG) begin
                if ({1'b0, held_cnt} + 3'd1 >= seq_len) begin
                    for (int i = 0; i < held_cnt; i++) begin
                        emit(held[i]);
                    end
                    emit(b);
                    held_cnt = 2'd0;
                    seq_len  = 3'd0;
                end else if (last) begin
                    flush_held();
                    emit(repl_byte);
                    err_seen = 1'b1;
                end else begin
                    held[held_cnt] = b;
                    held_cnt++;
                end
            end else begin
                flush_held();
                take_lead(b, last);
            end
        end else begin
            held_cnt = 2'd0;
            seq_len  = 3'd0;
            take_lead(b, last);
        end

        foreach (run_bytes[i]) begin
            cb.data     = run_bytes[i];
            cb.run_last = (i == run_bytes.size() - 1);
            cb.str_end  = cb.run_last && last;
            cb.had_err  = cb.str_end && err_seen;
            expected_q.push_back(cb);
        end
        if (last) begin
            held_cnt = 2'd0;
            seq_len  = 3'd0;
            err_seen = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_clean_byte exp_b;
        if (!i_rst_n) begin
            repl_byte = u8san_pkg::REPL_RESET;
            held_cnt  = 2'd0;
            seq_len   = 3'd0;
            err_seen  = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                repl_byte = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                sanitize_byte(i_in_byte, i_in_string_last);
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected output transaction, byte %h", $time, i_out_byte);
                    o_fail_count++;
                end else begin
                    exp_b = expected_q.pop_front();
                    if (i_out_byte != exp_b.data) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, exp_b.data, i_out_byte);
                        o_fail_count++;
                    end
                    if (i_out_run_last != exp_b.run_last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, exp_b.run_last, i_out_run_last);
                        o_fail_count++;
                    end
                    if (i_out_string_end != exp_b.str_end) begin
                        $display("%0t: string_end expected %b actual %b",
                                 $time, exp_b.str_end, i_out_string_end);
                        o_fail_count++;
                    end
                    if (i_out_string_had_error != exp_b.had_err) begin
                        $display("%0t: string_had_error expected %b actual %b",
                                 $time, exp_b.had_err, i_out_string_had_error);
                        o_fail_count++;
                    end
                end
            end
        end
        o_outstanding = expected_q.size();
    end

endmodule

[dv/tb_utf8_stream_sanitizer.sv]
// testbench top for the utf8 stream sanitizer: clock, reset, byte stream stimulus,
// output stall pattern and the final verdict
// depends on u8san_pkg, utf8_stream_sanitizer and utf8_san_checker
module tb_utf8_stream_sanitizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_PCT     = 16;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_string_end;
    logic       out_had_error;

    logic       hold_req;
    logic       quiet;
    int         fail_count;
    int         outstanding;
    int         out_seen;
    int         n_items;
    int         n_strings;
    int         n_settings;
    int         cycle_cnt;

    // {string_last, byte}: plain ascii, full 2/3/4-byte sequences, invalid leads,
    // broken sequence, cut off at end, lead at end, 4-byte lead broken after 3 held
    logic [8:0] directed_items [25] = '{
        9'h100, 9'h17F,
        9'h0C3, 9'h1A9,
        9'h0E2, 9'h082, 9'h1AC,
        9'h0F0, 9'h09F, 9'h098, 9'h180,
        9'h080, 9'h0BF, 9'h0F8, 9'h1FF,
        9'h0E2, 9'h141,
        9'h0E2, 9'h182,
        9'h1C3,
        9'h0F0, 9'h09F, 9'h098, 9'h0C3, 9'h1A9
    };

    utf8_stream_sanitizer u_top (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_in_byte              (in_byte),
        .i_in_string_last       (in_last),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_out_byte             (out_byte),
        .o_out_run_last         (out_run_last),
        .o_out_string_end       (out_string_end),
        .o_out_string_had_error (out_had_error)
    );

    utf8_san_checker u_checker (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .i_in_stall             (in_stall),
        .i_in_byte              (in_byte),
        .i_in_string_last       (in_last),
        .i_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .i_out_byte             (out_byte),
        .i_out_run_last         (out_run_last),
        .i_out_string_end       (out_string_end),
        .i_out_string_had_error (out_had_error),
        .o_fail_count           (fail_count),
        .o_outstanding          (outstanding),
        .o_out_seen             (out_seen)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("CHECKS FAILED");
        $finish;
    end

    // output side: one long hold-off on request, which takes priority; otherwise random stalls, none while quiet
    initial begin
        int held_cycles;
        held_cycles = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && held_cycles < HOLD_CYCLES) begin
                out_stall <= 1'b1;
                held_cycles++;
            end else if (quiet) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // one input transaction; returns at the edge where it is accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_items++;
    endtask

    // mostly well-formed sequences, some cut short, bad leads and raw noise
    task automatic send_string();
        logic [7:0] str_q [$];
        int n_tok;
        int r;
        int len;
        int k;
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                str_q.push_back(8'($urandom_range(0, 127)));
            end else if (r < 88) begin
                len = (r < 48) ? 2 : (r < 63) ? 3 : (r < 80) ? 4 : $urandom_range(2, 4);
                k   = (r < 80) ? len - 1 : $urandom_range(0, len - 2);
                case (len)
                    2: str_q.push_back({3'b110, 5'($urandom)});
                    3: str_q.push_back({4'b1110, 4'($urandom)});
                    default: str_q.push_back({5'b11110, 3'($urandom)});
                endcase
                repeat (k) str_q.push_back({2'b10, 6'($urandom)});
            end else if (r < 94) begin
                str_q.push_back(r[0] ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)});
            end else begin
                str_q.push_back(8'($urandom));
            end
        end
        foreach (str_q[i]) begin
            send_byte(str_q[i], i == str_q.size() - 1);
        end
        n_strings++;
    endtask

    // leaves the input idle until every expected byte is out and the block has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // the long output hold-off, if requested and not yet used, starts as the phase begins sending
    task automatic run_phase(input logic [7:0] repl, input int phase_items,
                             input logic hold);
        int stop_at;
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= repl;
        @(posedge clk);
        cfg_we   <= 1'b0;
        hold_req <= hold;
        n_settings++;
        stop_at = n_items + phase_items;
        while (n_items < stop_at) send_string();
    endtask

    initial begin
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= 8'h00;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        in_last  <= 1'b0;
        hold_req <= 1'b0;
        quiet    <= 1'b0;
        n_items    = 0;
        n_strings  = 0;
        n_settings = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases under the reset replacement byte
        foreach (directed_items[i]) begin
            send_byte(directed_items[i][7:0], directed_items[i][8]);
        end

        run_phase(8'h00, 90, 1'b0);
        run_phase(8'hFF, 90, 1'b1);
        quiet <= 1'b1;
        run_phase(8'($urandom), 90, 1'b1);
        quiet <= 1'b0;
        run_phase(u8san_pkg::REPL_RESET, 80, 1'b1);

        wait_drained();
        $display("covered %0d input and %0d output transactions over %0d strings",
                 n_items, out_seen, n_strings);
        $display("with %0d replacement byte settings, including 0x00 and 0xff",
                 n_settings);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/u8san_pkg.sv
sv/u8san_front.sv
sv/u8san_queue.sv
sv/u8san_back.sv
sv/utf8_stream_sanitizer.sv
dv/utf8_san_checker.sv
dv/tb_utf8_stream_sanitizer.sv
